### design/ostt_pkg.sv
package ostt_pkg;

  // Default sizes of the timer table.
  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;

  // Fixed field widths of the request and result channels.
  localparam int OP_W    = 2;
  localparam int SLOT_FW = 4;
  localparam int DUR_W   = 32;
  localparam int OWNER_W = 16;
  localparam int KIND_W  = 2;

  // Most expiries reported for one tick, and the width of their count.
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_ARM    = 2'd2,
    OP_CLOSE  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_OWNER,
    ST_CREATE,
    ST_CHECK,
    ST_ARM_ADD,
    ST_EMIT
  } state_t;

endpackage

### design/ostt_ram.sv
module ostt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ostt_unit.sv
module ostt_unit #(
  parameter int TIME_BITS = ostt_pkg::TIME_BITS_DEF
) (
  input  logic                 sub,
  input  logic [TIME_BITS-1:0] a,
  input  logic [TIME_BITS-1:0] b,
  output logic [TIME_BITS-1:0] sum,
  output logic                 lt,
  output logic                 eq
);

  localparam int W = TIME_BITS + 1;

  logic [TIME_BITS-1:0] b_op;
  logic [W-1:0]         raw;

  // A single adder: a + b for the clock and expiry, a - b for the compare.
  assign b_op = sub ? ~b : b;
  assign raw  = {1'b0, a} + {1'b0, b_op} + W'(sub);

  // An addition that carries out saturates at the top of the clock range.
  assign sum = (!sub && raw[TIME_BITS]) ? '1 : raw[TIME_BITS-1:0];

  // When subtracting, a carry out means a >= b.
  assign lt = sub && !raw[TIME_BITS];
  assign eq = sub && raw[TIME_BITS] && (raw[TIME_BITS-1:0] == '0);

endmodule

### design/one_shot_timer_table_top.sv
// Channel   Handshake              Payload
// request   cmd_valid / cmd_stall  op, slot, duration_ms, owner
// result    rsp_valid / rsp_stall  kind, slot_res, notify_owner, last
//
// Requests are taken one at a time; cmd_stall is high from acceptance until the
// last result of the request has been loaded into the result register.
// A tick scans the expiry RAM once when nothing is due. Every timer reported adds
// one more scan of the expiry RAM, except the report that reaches MAX_OUT, as no
// scan follows it. Create searches for a free slot. Reset takes effect at the next
// edge. A stalled result holds the sequencer in its emit step, which lengthens the
// request.
module one_shot_timer_table_top #(
  parameter int NUM_SLOTS = ostt_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = ostt_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [ostt_pkg::OP_W-1:0]    op,
  input  logic [ostt_pkg::SLOT_FW-1:0] slot,
  input  logic [ostt_pkg::DUR_W-1:0]   duration_ms,
  input  logic [ostt_pkg::OWNER_W-1:0] owner,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic [ostt_pkg::KIND_W-1:0]  kind,
  output logic [ostt_pkg::SLOT_FW-1:0] slot_res,
  output logic [ostt_pkg::OWNER_W-1:0] notify_owner,
  output logic                         last
);

  import ostt_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int EXT_W  = SLOT_W + SLOT_FW;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  state_t state, state_next;

  // Latched request.
  op_t                 req_op;
  logic                req_ok;
  logic [SLOT_W-1:0]   req_idx;
  logic [DUR_W-1:0]    req_dur;
  logic [OWNER_W-1:0]  req_owner;
  logic [EXT_W-1:0]    slot_ext;

  // Timer state held in flip-flops.
  logic [TIME_BITS-1:0] now_ms;
  logic [NUM_SLOTS-1:0] used;
  logic [NUM_SLOTS-1:0] armed;

  // Scan state.
  logic [SLOT_W-1:0]    scan_idx;
  logic [SLOT_W-1:0]    cmp_idx;
  logic                 cmp_vld;
  logic                 have;
  logic [SLOT_W-1:0]    best;
  logic [TIME_BITS-1:0] best_t;
  logic [CNT_W-1:0]     cnt;
  logic                 take;

  // Expiry held back until it is known whether another one follows.
  logic                 pend_v;
  logic [SLOT_W-1:0]    pend_slot;
  logic [OWNER_W-1:0]   pend_owner;

  // Next result to be loaded into the result register.
  kind_t                res_kind;
  logic [SLOT_W-1:0]    res_slot;
  logic [OWNER_W-1:0]   res_owner;
  logic                 res_last;
  logic [EXT_W-1:0]     res_slot_ext;
  logic                 rsp_free;

  // Memory ports.
  logic                 dur_we;
  logic [DUR_W-1:0]     dur_rdata;
  logic                 exp_we;
  logic [TIME_BITS-1:0] exp_rdata;
  logic [OWNER_W-1:0]   own_rdata;

  // Shared adder and comparator.
  logic                 u_sub;
  logic [TIME_BITS-1:0] u_a;
  logic [TIME_BITS-1:0] u_b;
  logic [TIME_BITS-1:0] u_sum;
  logic                 u_lt;
  logic                 u_eq;

  ostt_unit #(.TIME_BITS(TIME_BITS)) u_unit (
    .sub (u_sub),
    .a   (u_a),
    .b   (u_b),
    .sum (u_sum),
    .lt  (u_lt),
    .eq  (u_eq)
  );

  ostt_ram #(.WIDTH(DUR_W), .DEPTH(NUM_SLOTS)) u_dur_ram (
    .clk   (clk),
    .we    (dur_we),
    .waddr (scan_idx),
    .wdata (req_dur),
    .raddr (req_idx),
    .rdata (dur_rdata)
  );

  ostt_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_SLOTS)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (req_idx),
    .wdata (u_sum),
    .raddr (scan_idx),
    .rdata (exp_rdata)
  );

  ostt_ram #(.WIDTH(OWNER_W), .DEPTH(NUM_SLOTS)) u_own_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (req_idx),
    .wdata (req_owner),
    .raddr (best),
    .rdata (own_rdata)
  );

  assign slot_ext     = EXT_W'(slot);
  assign res_slot_ext = EXT_W'(res_slot);
  assign rsp_free     = !rsp_valid || !rsp_stall;

  // An armed slot becomes the candidate when it is strictly earlier than the best
  // so far; the first one only needs to be due (best_t starts at the clock).
  assign take = cmp_vld && armed[cmp_idx] && (u_lt || (u_eq && !have));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (op_t'(op))
            OP_TICK:   state_next = ST_TICK;
            OP_CREATE: state_next = ST_CREATE;
            default:   state_next = ST_CHECK;
          endcase
        end
      end
      ST_TICK: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (have && !pend_v) begin
          state_next = ST_OWNER;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_OWNER: begin
        if (cnt == CNT_W'(MAX_OUT)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_CREATE: begin
        if (!used[scan_idx] || scan_idx == LAST_IDX) begin
          state_next = ST_EMIT;
        end
      end
      ST_CHECK: begin
        if (req_ok && used[req_idx] && req_op == OP_ARM && !armed[req_idx]) begin
          state_next = ST_ARM_ADD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_ARM_ADD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (rsp_free) begin
          state_next = res_last ? ST_IDLE : ST_DECIDE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    cmd_stall = (state != ST_IDLE);
    dur_we    = (state == ST_CREATE) && !used[scan_idx];
    exp_we    = (state == ST_ARM_ADD);
    unique case (state)
      ST_TICK: begin
        u_sub = 1'b0;
        u_a   = now_ms;
        u_b   = TIME_BITS'(1);
      end
      ST_ARM_ADD: begin
        u_sub = 1'b0;
        u_a   = now_ms;
        u_b   = TIME_BITS'(dur_rdata);
      end
      default: begin
        u_sub = 1'b1;
        u_a   = exp_rdata;
        u_b   = best_t;
      end
    endcase
  end

  // Control state and timer flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now_ms    <= '0;
      used      <= '0;
      armed     <= '0;
      scan_idx  <= '0;
      cmp_vld   <= 1'b0;
      have      <= 1'b0;
      cnt       <= '0;
      pend_v    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == ST_SCAN);

      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_EMIT && rsp_free) begin
        rsp_valid <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            scan_idx <= '0;
          end
        end
        ST_TICK: begin
          now_ms   <= u_sum;
          scan_idx <= '0;
          have     <= 1'b0;
          cnt      <= '0;
        end
        ST_SCAN: begin
          if (scan_idx != LAST_IDX) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (take) begin
            have <= 1'b1;
          end
        end
        ST_SCAN_END: begin
          if (take) begin
            have <= 1'b1;
          end
        end
        ST_DECIDE: begin
          if (have && !pend_v) begin
            armed[best] <= 1'b0;
            cnt         <= cnt + 1'b1;
          end else begin
            pend_v <= 1'b0;
          end
        end
        ST_OWNER: begin
          if (cnt != CNT_W'(MAX_OUT)) begin
            pend_v   <= 1'b1;
            scan_idx <= '0;
            have     <= 1'b0;
          end
        end
        ST_CREATE: begin
          if (!used[scan_idx]) begin
            used[scan_idx]  <= 1'b1;
            armed[scan_idx] <= 1'b0;
          end else if (scan_idx != LAST_IDX) begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        ST_CHECK: begin
          if (req_ok && used[req_idx] && req_op == OP_CLOSE) begin
            used[req_idx]  <= 1'b0;
            armed[req_idx] <= 1'b0;
          end
        end
        ST_ARM_ADD: begin
          armed[req_idx] <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;

    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          req_op    <= op_t'(op);
          req_ok    <= (slot_ext < EXT_W'(NUM_SLOTS));
          req_idx   <= slot_ext[SLOT_W-1:0];
          req_dur   <= duration_ms;
          req_owner <= owner;
        end
      end
      ST_TICK: begin
        best_t <= u_sum;
      end
      ST_SCAN, ST_SCAN_END: begin
        if (take) begin
          best   <= cmp_idx;
          best_t <= exp_rdata;
        end
      end
      ST_DECIDE: begin
        if (have && pend_v) begin
          res_kind  <= KIND_EXPIRED;
          res_slot  <= pend_slot;
          res_owner <= pend_owner;
          res_last  <= 1'b0;
        end else if (!have) begin
          res_kind  <= pend_v ? KIND_EXPIRED : KIND_DONE;
          res_slot  <= pend_v ? pend_slot : '0;
          res_owner <= pend_v ? pend_owner : '0;
          res_last  <= 1'b1;
        end
      end
      ST_OWNER: begin
        if (cnt == CNT_W'(MAX_OUT)) begin
          res_kind  <= KIND_EXPIRED;
          res_slot  <= best;
          res_owner <= own_rdata;
          res_last  <= 1'b1;
        end else begin
          pend_slot  <= best;
          pend_owner <= own_rdata;
          best_t     <= now_ms;
        end
      end
      ST_CREATE: begin
        if (!used[scan_idx]) begin
          res_kind  <= KIND_CREATED;
          res_slot  <= scan_idx;
          res_owner <= '0;
          res_last  <= 1'b1;
        end else if (scan_idx == LAST_IDX) begin
          res_kind  <= KIND_ERROR;
          res_slot  <= '0;
          res_owner <= '0;
          res_last  <= 1'b1;
        end
      end
      ST_CHECK: begin
        res_kind  <= (req_ok && used[req_idx]) ? KIND_DONE : KIND_ERROR;
        res_slot  <= '0;
        res_owner <= '0;
        res_last  <= 1'b1;
      end
      ST_EMIT: begin
        if (rsp_free) begin
          kind         <= res_kind;
          slot_res     <= res_slot_ext[SLOT_FW-1:0];
          notify_owner <= res_owner;
          last         <= res_last;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### tb/sv/one_shot_timer_table_check.sv
`timescale 1ns / 1ps

module one_shot_timer_table_check #(
  parameter int NUM_SLOTS = ostt_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = ostt_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  logic [ostt_pkg::OP_W-1:0]    op,
  input  logic [ostt_pkg::SLOT_FW-1:0] slot,
  input  logic [ostt_pkg::DUR_W-1:0]   duration_ms,
  input  logic [ostt_pkg::OWNER_W-1:0] owner,
  input  logic                         rsp_valid,
  input  logic                         rsp_stall,
  input  logic [ostt_pkg::KIND_W-1:0]  kind,
  input  logic [ostt_pkg::SLOT_FW-1:0] slot_res,
  input  logic [ostt_pkg::OWNER_W-1:0] notify_owner,
  input  logic                         last,
  output int                           fail_count,
  output int                           pending,
  output int                           requests_seen,
  output int                           results_seen,
  output int                           expiries_seen,
  output int                           errors_seen,
  output int                           widest_burst
);

  import ostt_pkg::*;

  typedef struct {
    kind_t               res_kind;
    logic [SLOT_FW-1:0]  res_slot;
    logic [OWNER_W-1:0]  res_owner;
    logic                res_last;
  } timer_result_t;

  // Shadow copy of the timer table.
  logic [TIME_BITS-1:0] clock_ms;
  bit                   slot_live    [NUM_SLOTS];
  bit                   slot_pending [NUM_SLOTS];
  logic [DUR_W-1:0]     slot_len     [NUM_SLOTS];
  logic [TIME_BITS-1:0] slot_due     [NUM_SLOTS];
  logic [OWNER_W-1:0]   slot_client  [NUM_SLOTS];

  // Results still owed by the block, oldest first.
  timer_result_t awaited [$];
  int            burst_len;

  // Clock arithmetic saturates at the top of the time range.
  function automatic logic [TIME_BITS-1:0] clock_plus(input logic [TIME_BITS-1:0] base,
                                                      input logic [DUR_W-1:0] delta);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, base} + delta;
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

  function automatic void await_result(input kind_t k, input int s,
                                       input logic [OWNER_W-1:0] w, input logic l);
    timer_result_t r;
    r.res_kind  = k;
    r.res_slot  = SLOT_FW'(s);
    r.res_owner = w;
    r.res_last  = l;
    awaited = {awaited, r};
  endfunction

  // Applies one request to the shadow table and queues the results it owes.
  function automatic void predict_request(input op_t code, input logic [SLOT_FW-1:0] s,
                                          input logic [DUR_W-1:0] d,
                                          input logic [OWNER_W-1:0] w);
    int                   idx;
    int                   free_slot;
    int                   due_first;
    logic [TIME_BITS-1:0] first_due;
    int                   fired [$];
    idx = int'(s);
    case (code)
      OP_TICK: begin
        clock_ms = clock_plus(clock_ms, 1);
        // Earliest expiry first; the strict compare keeps the lowest slot on ties.
        while (fired.size() < MAX_OUT) begin
          due_first = -1;
          first_due = '0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_pending[i] && slot_due[i] <= clock_ms &&
                (due_first < 0 || slot_due[i] < first_due)) begin
              due_first = i;
              first_due = slot_due[i];
            end
          end
          if (due_first < 0) break;
          slot_pending[due_first] = 1'b0;
          fired = {fired, due_first};
        end
        if (fired.size() == 0) await_result(KIND_DONE, 0, '0, 1'b1);
        foreach (fired[k]) begin
          await_result(KIND_EXPIRED, fired[k], slot_client[fired[k]], k == fired.size() - 1);
        end
      end
      OP_CREATE: begin
        free_slot = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (free_slot < 0 && !slot_live[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          await_result(KIND_ERROR, 0, '0, 1'b1);
        end else begin
          slot_live[free_slot]    = 1'b1;
          slot_pending[free_slot] = 1'b0;
          slot_len[free_slot]     = d;
          await_result(KIND_CREATED, free_slot, '0, 1'b1);
        end
      end
      default: begin
        // Arm and close both need a slot that is in use.
        if (idx >= NUM_SLOTS || !slot_live[idx]) begin
          await_result(KIND_ERROR, 0, '0, 1'b1);
        end else begin
          if (code == OP_ARM) begin
            if (!slot_pending[idx]) begin
              slot_pending[idx] = 1'b1;
              slot_due[idx]     = clock_plus(clock_ms, slot_len[idx]);
              slot_client[idx]  = w;
            end
          end else begin
            slot_live[idx]    = 1'b0;
            slot_pending[idx] = 1'b0;
          end
          await_result(KIND_DONE, 0, '0, 1'b1);
        end
      end
    endcase
  endfunction

  // Compares one accepted result with the oldest one owed.
  function automatic void check_result();
    timer_result_t want;
    results_seen++;
    if (kind == KIND_EXPIRED) expiries_seen++;
    if (kind == KIND_ERROR) errors_seen++;
    burst_len++;
    if (last) begin
      if (burst_len > widest_burst) widest_burst = burst_len;
      burst_len = 0;
    end
    if (awaited.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t: result kind %0d slot %0d owner %h last %b arrived with none owed",
                 $time, kind, slot_res, notify_owner, last);
      end
    end else begin
      want = awaited.pop_front();
      if (kind !== want.res_kind || slot_res !== want.res_slot ||
          notify_owner !== want.res_owner || last !== want.res_last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: result mismatch: expected kind %0d slot %0d owner %h last %b,",
                   $time, want.res_kind, want.res_slot, want.res_owner, want.res_last);
          $display("    got kind %0d slot %0d owner %h last %b",
                   kind, slot_res, notify_owner, last);
        end
      end
    end
  endfunction

  // Watch both channels at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      clock_ms = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_live[i]    = 1'b0;
        slot_pending[i] = 1'b0;
        slot_len[i]     = '0;
        slot_due[i]     = '0;
        slot_client[i]  = '0;
      end
      awaited.delete();
      burst_len     = 0;
      fail_count    = 0;
      requests_seen = 0;
      results_seen  = 0;
      expiries_seen = 0;
      errors_seen   = 0;
      widest_burst  = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        requests_seen++;
        predict_request(op_t'(op), slot, duration_ms, owner);
      end
      if (rsp_valid && !rsp_stall) check_result();
    end
    pending = awaited.size();
  end

endmodule

### tb/sv/one_shot_timer_table_top_test.sv
`timescale 1ns / 1ps

module one_shot_timer_table_top_test;
  import ostt_pkg::*;

  localparam int SLOTS            = NUM_SLOTS_DEF;
  localparam int RANDOM_PER_PHASE = 30;
  localparam int LONG_HOLD        = 400;
  localparam int DRAIN_LIMIT      = 50000;
  localparam int SETTLE           = 60;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cmd_valid   = 1'b0;
  logic               cmd_stall;
  logic [OP_W-1:0]    op          = '0;
  logic [SLOT_FW-1:0] slot        = '0;
  logic [DUR_W-1:0]   duration_ms = '0;
  logic [OWNER_W-1:0] owner       = '0;
  logic               rsp_valid;
  logic               rsp_stall   = 1'b0;
  logic [KIND_W-1:0]  kind;
  logic [SLOT_FW-1:0] slot_res;
  logic [OWNER_W-1:0] notify_owner;
  logic               last;

  int fail_count;
  int pending;
  int requests_seen;
  int results_seen;
  int expiries_seen;
  int errors_seen;
  int widest_burst;

  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  bit             long_hold_req = 1'b0;
  logic [SLOTS-1:0] live_slots  = '0;

  one_shot_timer_table_top dut (.*);

  one_shot_timer_table_check checker_i (.*);

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Offers one request and waits until the block takes it.
  task automatic offer(input op_t code, input logic [SLOT_FW-1:0] s,
                       input logic [DUR_W-1:0] d, input logic [OWNER_W-1:0] w);
    int lowest;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid   <= 1'b1;
    op          <= code;
    slot        <= s;
    duration_ms <= d;
    owner       <= w;
    do @(posedge clk); while (cmd_stall);
    // Keep track of the slots in use so that later arms and closes can hit them.
    if (code == OP_CREATE) begin
      lowest = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (lowest < 0 && !live_slots[i]) lowest = i;
      end
      if (lowest >= 0) live_slots[lowest] = 1'b1;
    end else if (code == OP_CLOSE && int'(s) < SLOTS) begin
      live_slots[s] = 1'b0;
    end
  endtask

  // Mostly a slot in use, sometimes any slot at all.
  function automatic logic [SLOT_FW-1:0] pick_slot();
    int s;
    if (live_slots != '0 && $urandom_range(0, 99) < 85) begin
      do s = $urandom_range(0, SLOTS - 1); while (!live_slots[s]);
    end else begin
      s = $urandom_range(0, 15);
    end
    return SLOT_FW'(s);
  endfunction

  task automatic random_request();
    int               pick;
    logic [DUR_W-1:0] len;
    pick = $urandom_range(0, 99);
    len  = $urandom;
    if (pick < 35) begin
      offer(OP_TICK, SLOT_FW'($urandom_range(0, 15)), len, OWNER_W'($urandom));
    end else if (pick < 55) begin
      // Short timeouts so that most timers fire within the run.
      if ($urandom_range(0, 9) < 7) len = $urandom_range(0, 6);
      else if ($urandom_range(0, 2) == 0) len = '1;
      offer(OP_CREATE, SLOT_FW'($urandom_range(0, 15)), len, OWNER_W'($urandom));
    end else if (pick < 85) begin
      offer(OP_ARM, pick_slot(), len, OWNER_W'($urandom));
    end else begin
      offer(OP_CLOSE, pick_slot(), len, OWNER_W'($urandom));
    end
  endtask

  // Fills the table, arms every slot, lets them fire and frees them all again.
  task automatic fill_and_fire(input int max_len, input bit squeeze);
    while (live_slots != '1) begin
      offer(OP_CREATE, SLOT_FW'($urandom_range(0, 15)), DUR_W'($urandom_range(0, max_len)),
            OWNER_W'($urandom));
    end
    offer(OP_CREATE, SLOT_FW'($urandom_range(0, 15)), $urandom, OWNER_W'($urandom));
    for (int i = 0; i < SLOTS; i++) begin
      offer(OP_ARM, SLOT_FW'(i), $urandom, OWNER_W'($urandom));
    end
    if (squeeze) long_hold_req = 1'b1;
    repeat (max_len + 2) begin
      offer(OP_TICK, SLOT_FW'($urandom_range(0, 15)), $urandom, OWNER_W'($urandom));
    end
    for (int i = 0; i < SLOTS; i++) begin
      offer(OP_CLOSE, SLOT_FW'(i), $urandom, OWNER_W'($urandom));
    end
  endtask

  // Request stream and verdict.
  initial begin
    int waited;
    send_idle_pct = 28;
    recv_idle_pct = 82;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty table: idle tick, arm and close of unused slots.
    offer(OP_TICK, 4'd0, '0, '0);
    offer(OP_ARM, 4'd5, '1, '1);
    offer(OP_CLOSE, 4'd15, '0, '0);
    // Zero, largest and short timeouts.
    offer(OP_CREATE, 4'd15, '0, '0);
    offer(OP_CREATE, 4'd0, '1, '0);
    offer(OP_CREATE, 4'd0, 32'd2, '0);
    offer(OP_ARM, 4'd0, '0, '1);
    // A second arm of an armed timer changes nothing.
    offer(OP_ARM, 4'd0, '0, 16'h1234);
    offer(OP_ARM, 4'd1, '0, '0);
    offer(OP_ARM, 4'd2, '0, 16'h00aa);
    offer(OP_TICK, 4'd0, '0, '0);
    // Close cancels a pending expiry; the freed slot then answers with errors.
    offer(OP_CLOSE, 4'd1, '0, '0);
    offer(OP_CLOSE, 4'd1, '0, '0);
    offer(OP_ARM, 4'd1, '0, '0);
    // Equal expiries in slots out of slot order, reported earliest first.
    offer(OP_CREATE, 4'd0, 32'd1, '0);
    offer(OP_CREATE, 4'd0, '0, '0);
    offer(OP_ARM, 4'd3, '0, 16'h3333);
    offer(OP_ARM, 4'd1, '0, 16'h1111);
    offer(OP_ARM, 4'd0, '0, 16'h0000);
    offer(OP_TICK, 4'd0, '0, '0);
    offer(OP_TICK, 4'd0, '0, '0);
    for (int i = 0; i < 4; i++) offer(OP_CLOSE, SLOT_FW'(i), '0, '0);

    // Sender mostly busy, receiver mostly stalled; all sixteen fire at one tick.
    fill_and_fire(0, 1'b0);
    repeat (RANDOM_PER_PHASE) random_request();

    send_idle_pct = 82;
    recv_idle_pct = 28;
    fill_and_fire(3, 1'b0);
    repeat (RANDOM_PER_PHASE) random_request();

    // No idling; the receiver holds off long enough to back the block up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_and_fire(2, 1'b1);
    repeat (RANDOM_PER_PHASE) random_request();
    cmd_valid <= 1'b0;

    // Wait for every owed result, then a little longer for strays.
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pending != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE) @(negedge clk);

    $display("Run covered %0d requests and %0d results: %0d expiries, %0d errors,",
             requests_seen, results_seen, expiries_seen, errors_seen);
    $display("up to %0d results for one request, idle mixes 28/82, 82/28, 0/0, hold-off %0d.",
             widest_burst, LONG_HOLD);
    if (pending != 0) $display("%0d results still owed at the end", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("Timed out with %0d results still owed.", pending);
    $display("FAIL");
    $finish;
  end

endmodule
